[sv/ecg_bandpass_fir_rectify_defines.svh]
// assertion macros for the ecg band-pass filter block
`ifndef ECG_BANDPASS_FIR_RECTIFY_DEFINES_SVH
`define ECG_BANDPASS_FIR_RECTIFY_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define ECGBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define ECGBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ecgbp_pkg.sv]
// constants, coefficient rom and helpers for the ecg band-pass filter block
package ecgbp_pkg;

   localparam int ORDER_DEF       = 161;
   localparam int SAMPLE_BITS_DEF = 10;

   localparam int ROM_SIZE    = 162;
   localparam int ROM_IDX_W   = 8;
   localparam int COEF_W      = 16;
   localparam int ACC_W       = 48;
   localparam int SCALE_SHIFT = 18;
   localparam int OUT_W       = 12;
   localparam int OUT_MAX     = 4095;

   localparam int THRESH_W    = 32;
   localparam int OFFSET_W    = 12;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [THRESH_W-1:0] THRESH_RESET = 32'sd200;
   localparam logic [OFFSET_W-1:0]        OFFSET_RESET = 12'd512;

   localparam logic [CSR_IDX_W-1:0] CSR_RECTIFY_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_OFFSET     = 4'd1;

   localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_SIZE] = '{
      -16'sd1, -16'sd2, -16'sd4, -16'sd6, -16'sd8, -16'sd11, -16'sd14, -16'sd16,
      -16'sd18, -16'sd18, -16'sd17, -16'sd15, -16'sd10, -16'sd4, 16'sd4, 16'sd12,
      16'sd19, 16'sd23, 16'sd25, 16'sd21, 16'sd13, 16'sd0, -16'sd17, -16'sd36,
      -16'sd54, -16'sd66, -16'sd68, -16'sd56, -16'sd24, 16'sd30, 16'sd107, 16'sd205,
      16'sd322, 16'sd449, 16'sd577, 16'sd693, 16'sd785, 16'sd840, 16'sd848, 16'sd801,
      16'sd697, 16'sd540, 16'sd340, 16'sd115, -16'sd113, -16'sd320, -16'sd478,
      -16'sd566, -16'sd564, -16'sd464, -16'sd271, 16'sd0, 16'sd317, 16'sd637,
      16'sd906, 16'sd1066, 16'sd1058, 16'sd831, 16'sd346, -16'sd415, -16'sd1444,
      -16'sd2708, -16'sd4141, -16'sd5654, -16'sd7133, -16'sd8453, -16'sd9481,
      -16'sd10093, -16'sd10183, -16'sd9673, -16'sd8525, -16'sd6744, -16'sd4387,
      -16'sd1552, 16'sd1615, 16'sd4939, 16'sd8222, 16'sd11262, 16'sd13863,
      16'sd15855, 16'sd17107, 16'sd17534, 16'sd17107, 16'sd15855, 16'sd13863,
      16'sd11262, 16'sd8222, 16'sd4939, 16'sd1615, -16'sd1552, -16'sd4387,
      -16'sd6744, -16'sd8525, -16'sd9673, -16'sd10183, -16'sd10093, -16'sd9481,
      -16'sd8453, -16'sd7133, -16'sd5654, -16'sd4141, -16'sd2708, -16'sd1444,
      -16'sd415, 16'sd346, 16'sd831, 16'sd1058, 16'sd1066, 16'sd906, 16'sd637,
      16'sd317, 16'sd0, -16'sd271, -16'sd464, -16'sd564, -16'sd566, -16'sd478,
      -16'sd320, -16'sd113, 16'sd115, 16'sd340, 16'sd540, 16'sd697, 16'sd801,
      16'sd848, 16'sd840, 16'sd785, 16'sd693, 16'sd577, 16'sd449, 16'sd322,
      16'sd205, 16'sd107, 16'sd30, -16'sd24, -16'sd56, -16'sd68, -16'sd66,
      -16'sd54, -16'sd36, -16'sd17, 16'sd0, 16'sd13, 16'sd21, 16'sd25, 16'sd23,
      16'sd19, 16'sd12, 16'sd4, -16'sd4, -16'sd10, -16'sd15, -16'sd17, -16'sd18,
      -16'sd18, -16'sd16, -16'sd14, -16'sd11, -16'sd8, -16'sd6, -16'sd4, -16'sd2
   };

   // taps past the end of the rom weigh zero
   function automatic logic signed [COEF_W-1:0] tap_weight(input logic [ROM_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] w;
      if (idx < ROM_IDX_W'(ROM_SIZE)) begin
         w = COEF_ROM[idx];
      end else begin
         w = '0;
      end
      return w;
   endfunction

endpackage

[sv/ecg_bandpass_fir_rectify.sv]
// Band-pass FIR filter for one ECG channel with rectification, scaling and offset.
// Each request writes one sample into a ring of the last ORDER+1 samples held in a
// single-port synchronous memory. Until the ring has been filled once, a request
// returns filtered = 0 with valid_res = 0. From the request that fills
// the ring on, one shared multiplier walks the ring one tap per cycle, oldest sample
// first, through the one memory read port. The sum is zeroed below rectify_threshold,
// shifted right by 18, offset by output_offset and clamped to 0..4095. A new request
// is taken while a finished result still waits on rsp_stall. Configuration is
// written through csr_wr_en / csr_index / csr_wr_data; the user must write it only
// while idle, which the block itself does not enforce. Index 0 is rectify_threshold
// and index 1 is output_offset.
`include "ecg_bandpass_fir_rectify_defines.svh"

module ecg_bandpass_fir_rectify #(
   parameter int ORDER       = ecgbp_pkg::ORDER_DEF,
   parameter int SAMPLE_BITS = ecgbp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ecgbp_pkg::OUT_W-1:0]         rsp_filtered,
   output logic                                rsp_valid_res,
   input  logic                                csr_wr_en,
   input  logic [ecgbp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ecgbp_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int TAPS   = ORDER + 1;
   localparam int PTR_W  = $clog2(TAPS);
   localparam int PROD_W = SAMPLE_BITS + 1 + ecgbp_pkg::COEF_W;
   localparam int ACC_W  = ecgbp_pkg::ACC_W;
   localparam int SUM_W  = ACC_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] ring_mem [TAPS];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] fill_ff, fill_in;
   logic             full_ff, full_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] tap_ff, tap_in;
   logic             rd_vld_ff;
   logic             prod_vld_ff;

   logic signed [ecgbp_pkg::COEF_W-1:0] coef_ff;
   logic signed [PROD_W-1:0]            prod_ff;
   logic signed [ACC_W-1:0]             acc_ff, acc_in;

   logic signed [ecgbp_pkg::THRESH_W-1:0] thresh_ff;
   logic [ecgbp_pkg::OFFSET_W-1:0]        offset_ff;

   logic                          rsp_valid_ff;
   logic [ecgbp_pkg::OUT_W-1:0]   rsp_filtered_ff;
   logic                          rsp_valid_res_ff;

   logic                          req_accept;
   logic                          rsp_load;
   logic signed [ACC_W-1:0]       rect_acc;
   logic signed [ACC_W-1:0]       scaled;
   logic signed [SUM_W-1:0]       sum;
   logic [ecgbp_pkg::OUT_W-1:0]   result;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sample ring memory
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ring_mem[wp_ff] <= req_sample;
      end
      rd_data_ff <= ring_mem[rd_ptr_ff];
   end

   // ring bookkeeping and state
   always_comb begin
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      full_in   = full_ff;
      rd_ptr_in = rd_ptr_ff;
      tap_in    = tap_ff;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               wp_in = (wp_ff == PTR_W'(ORDER)) ? '0 : wp_ff + 1'b1;
               if (!full_ff) begin
                  if (fill_ff == PTR_W'(ORDER)) begin
                     full_in = 1'b1;
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
               rd_ptr_in = wp_in;
               tap_in    = PTR_W'(ORDER);
               state_in  = full_in ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            rd_ptr_in = (rd_ptr_ff == PTR_W'(ORDER)) ? '0 : rd_ptr_ff + 1'b1;
            tap_in    = tap_ff - 1'b1;
            if (tap_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wp_ff       <= '0;
         fill_ff     <= '0;
         full_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         full_ff     <= full_in;
         rd_vld_ff   <= (state_ff == ST_RUN);
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // multiply-accumulate pipeline
   always_comb begin
      acc_in = acc_ff;
      if (req_accept) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      tap_ff    <= tap_in;
      coef_ff   <= ecgbp_pkg::tap_weight(ecgbp_pkg::ROM_IDX_W'(tap_ff));
      prod_ff   <= $signed({1'b0, rd_data_ff}) * coef_ff;
      acc_ff    <= acc_in;
   end

   // rectify, scale, offset, clamp
   always_comb begin
      rect_acc = (acc_ff < ACC_W'(thresh_ff)) ? '0 : acc_ff;
      scaled   = rect_acc >>> ecgbp_pkg::SCALE_SHIFT;
      sum      = SUM_W'(scaled) + $signed(SUM_W'(offset_ff));
      if (sum < 0) begin
         result = '0;
      end else if (sum > $signed(SUM_W'(ecgbp_pkg::OUT_MAX))) begin
         result = ecgbp_pkg::OUT_W'(ecgbp_pkg::OUT_MAX);
      end else begin
         result = sum[ecgbp_pkg::OUT_W-1:0];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ecgbp_pkg::THRESH_RESET;
         offset_ff <= ecgbp_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == ecgbp_pkg::CSR_RECTIFY_THRESHOLD) begin
            thresh_ff <= $signed(csr_wr_data[ecgbp_pkg::THRESH_W-1:0]);
         end
         if (csr_index == ecgbp_pkg::CSR_OUTPUT_OFFSET) begin
            offset_ff <= csr_wr_data[ecgbp_pkg::OFFSET_W-1:0];
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff  <= full_ff ? result : '0;
         rsp_valid_res_ff <= full_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

   `ECGBP_ASSERT_NOW(a_wp_range, 1'b1, wp_ff <= PTR_W'(ORDER),
      "write pointer past last ring slot")
   `ECGBP_ASSERT_NEXT(a_run_start, req_accept && full_in,
      state_ff == ST_RUN && tap_ff == PTR_W'(ORDER) && acc_ff == '0,
      "tap walk did not start from a cleared accumulator")
   `ECGBP_ASSERT_NOW(a_mac_in_walk, rd_vld_ff || prod_vld_ff,
      state_ff == ST_RUN || state_ff == ST_DRAIN,
      "tap pipeline busy outside the tap walk")
   `ECGBP_ASSERT_NOW(a_valid_res_full, rsp_valid_ff && rsp_valid_res_ff, full_ff,
      "valid result before the ring filled")

endmodule
